@@ rtl/core/tclp_pkg.sv @@
`timescale 1ns / 1ps
// tclp_pkg: shared types, message codes and keyword tables of the command line parser
// no dependencies; imported by every module of the block

package tclp_pkg;

    // one input transfer: a message byte and the end-of-buffer flag
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    // one result transfer
    typedef struct packed {
        logic [2:0]  msg_type;
        logic [3:0]  first_arg_len;
        logic [63:0] first_arg_text;
        logic [3:0]  second_arg_len;
        logic [63:0] second_arg_text;
    } out_item_t;

    // character classes worked out by the front end
    typedef struct packed {
        logic space;
        logic digit;
        logic alpha;
        logic cr;
        logic lf;
    } char_class_t;

    // queue entry between front and back
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        char_class_t cls;
    } q_entry_t;

    // message type codes
    localparam logic [2:0] MSG_ERROR   = 3'd0;
    localparam logic [2:0] MSG_GOTMOVE = 3'd1;
    localparam logic [2:0] MSG_JOIN    = 3'd2;
    localparam logic [2:0] MSG_LEAVE   = 3'd3;
    localparam logic [2:0] MSG_LOGOUT  = 3'd4;
    localparam logic [2:0] MSG_LOGIN   = 3'd5;
    localparam logic [2:0] MSG_MOVE    = 3'd6;
    localparam logic [2:0] MSG_OK      = 3'd7;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int KW_COUNT = 7;

    // keyword text, first character in bits 7:0
    function automatic logic [55:0] kw_text(input logic [2:0] code);
        logic [55:0] t;
        t = '0;
        case (code)
            MSG_GOTMOVE: t = {"E", "V", "O", "M", "T", "O", "G"};
            MSG_JOIN:    t = {24'h0, "N", "I", "O", "J"};
            MSG_LEAVE:   t = {16'h0, "E", "V", "A", "E", "L"};
            MSG_LOGOUT:  t = {8'h0, "T", "U", "O", "G", "O", "L"};
            MSG_LOGIN:   t = {16'h0, "N", "I", "G", "O", "L"};
            MSG_MOVE:    t = {24'h0, "E", "V", "O", "M"};
            MSG_OK:      t = {40'h0, "K", "O"};
            default:     t = '0;
        endcase
        return t;
    endfunction

    // keyword length in characters
    function automatic logic [2:0] kw_len(input logic [2:0] code);
        logic [2:0] n;
        n = 3'd0;
        case (code)
            MSG_GOTMOVE: n = 3'd7;
            MSG_JOIN:    n = 3'd4;
            MSG_LEAVE:   n = 3'd5;
            MSG_LOGOUT:  n = 3'd6;
            MSG_LOGIN:   n = 3'd5;
            MSG_MOVE:    n = 3'd4;
            MSG_OK:      n = 3'd2;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/tclp_front.sv @@
`timescale 1ns / 1ps
// tclp_front: classifies each incoming byte for the parser back end
// depends on tclp_pkg

module tclp_front (
    input  tclp_pkg::in_item_t in_item,
    output tclp_pkg::q_entry_t entry
);
    import tclp_pkg::*;

    logic [7:0] ch;

    assign ch = in_item.byte_in;

    // class flags; high bytes fall in no class
    always_comb begin
        entry.ch        = ch;
        entry.last      = in_item.last_byte;
        entry.cls.space = ch inside {8'h20, [8'h09:8'h0C]};
        entry.cls.digit = ch inside {[8'h30:8'h39]};
        entry.cls.alpha = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        entry.cls.cr    = (ch == CHAR_CR);
        entry.cls.lf    = (ch == CHAR_LF);
    end

endmodule

@@ rtl/core/tclp_queue.sv @@
`timescale 1ns / 1ps
// tclp_queue: two-entry queue of classified bytes between front and back
// depends on tclp_pkg

module tclp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  tclp_pkg::q_entry_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output tclp_pkg::q_entry_t rd_data
);
    import tclp_pkg::*;

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/tclp_back.sv @@
`timescale 1ns / 1ps
// tclp_back: parser state machine over classified bytes, with the result register
// depends on tclp_pkg

module tclp_back #(
    parameter int MAX_ARG_CHARS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  tclp_pkg::q_entry_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tclp_pkg::out_item_t m_item
);
    import tclp_pkg::*;

    localparam logic [3:0] MAX_LEN = 4'(MAX_ARG_CHARS);

    typedef enum logic [8:0] {
        PH_LEAD  = 9'b000000001,
        PH_KEY   = 9'b000000010,
        PH_SKIP1 = 9'b000000100,
        PH_ARG1  = 9'b000001000,
        PH_SKIP2 = 9'b000010000,
        PH_ARG2  = 9'b000100000,
        PH_TRAIL = 9'b001000000,
        PH_CR    = 9'b010000000,
        PH_DONE  = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prog_reg, prog_next;
    logic [6:0]  alive_reg, alive_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        failed_reg, failed_next;
    logic [3:0]  arg1_cnt_reg, arg1_cnt_next;
    logic [63:0] arg1_txt_reg, arg1_txt_next;
    logic [3:0]  arg2_cnt_reg, arg2_cnt_next;
    logic [63:0] arg2_txt_reg, arg2_txt_next;
    logic        m_valid_reg;
    out_item_t   m_item_reg, m_item_next;
    logic        pop;

    // keywords that still agree with the typed prefix and continue with ch
    function automatic logic [6:0] key_match(input logic [6:0] alive, input logic [2:0] pos,
                                             input logic [7:0] ch);
        logic [6:0]  hit;
        logic [55:0] txt;
        hit = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            txt    = kw_text(3'(k + 1));
            hit[k] = alive[k] && (kw_len(3'(k + 1)) > pos) && (txt[{pos, 3'b000} +: 8] == ch);
        end
        return hit;
    endfunction

    // lowest command code among the matching keywords
    function automatic logic [2:0] first_cmd(input logic [6:0] hit);
        logic [2:0] code;
        code = MSG_ERROR;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (hit[k]) begin
                code = 3'(k + 1);
            end
        end
        return code;
    endfunction

    // result slot frees when empty or being taken
    assign pop     = q_valid && (!q_data.last || !m_valid_reg || m_ready);
    assign q_ready = pop;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // one byte through the phase chain; a byte that ends a token is
    // reexamined by the following phase
    always_comb begin
        phase_t     ph;
        logic [2:0] prog;
        logic [6:0] alive;
        logic [2:0] cmd;
        logic       fail;
        logic [3:0] c1n, c2n;
        logic [63:0] c1t, c2t;
        logic       pending;
        logic [6:0] hit;
        logic       ok;

        ph      = phase_reg;
        prog    = prog_reg;
        alive   = alive_reg;
        cmd     = cmd_reg;
        fail    = failed_reg;
        c1n     = arg1_cnt_reg;
        c1t     = arg1_txt_reg;
        c2n     = arg2_cnt_reg;
        c2t     = arg2_txt_reg;
        pending = 1'b1;
        hit     = '0;
        ok      = 1'b0;

        for (int i = 0; i < 5; i++) begin
            if (pending && !fail) begin
                case (ph)
                    PH_LEAD: begin
                        if (q_data.cls.space) begin
                            pending = 1'b0;
                        end else begin
                            prog  = 3'd0;
                            alive = '1;
                            ph    = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        hit = key_match(alive, prog, q_data.ch);
                        if (hit == '0) begin
                            fail = 1'b1;
                        end else begin
                            alive   = hit;
                            cmd     = first_cmd(hit);
                            prog    = prog + 3'd1;
                            pending = 1'b0;
                            if (prog == kw_len(cmd)) begin
                                if (cmd == MSG_GOTMOVE || cmd == MSG_MOVE || cmd == MSG_LOGIN) begin
                                    ph = PH_SKIP1;
                                end else begin
                                    ph = PH_TRAIL;
                                end
                            end
                        end
                    end
                    PH_SKIP1: begin
                        if (q_data.cls.space) begin
                            prog    = 3'd0;
                            pending = 1'b0;
                        end else if (cmd == MSG_LOGIN && prog != 3'd0 && q_data.cls.alpha) begin
                            // login run straight into a letter
                            fail = 1'b1;
                        end else begin
                            ph = PH_ARG1;
                        end
                    end
                    PH_ARG1: begin
                        ok = q_data.cls.digit || (cmd == MSG_LOGIN && q_data.cls.alpha);
                        if (c1n < MAX_LEN && ok) begin
                            c1t[{c1n[2:0], 3'b000} +: 8] = q_data.ch;
                            c1n     = c1n + 4'd1;
                            pending = 1'b0;
                        end else if (c1n == 4'd0) begin
                            fail = 1'b1;
                        end else begin
                            ph = (cmd == MSG_LOGIN) ? PH_TRAIL : PH_SKIP2;
                        end
                    end
                    PH_SKIP2: begin
                        if (q_data.cls.space) begin
                            pending = 1'b0;
                        end else begin
                            ph = PH_ARG2;
                        end
                    end
                    PH_ARG2: begin
                        if (c2n < MAX_LEN && q_data.cls.digit) begin
                            c2t[{c2n[2:0], 3'b000} +: 8] = q_data.ch;
                            c2n     = c2n + 4'd1;
                            pending = 1'b0;
                        end else if (c2n == 4'd0) begin
                            fail = 1'b1;
                        end else begin
                            ph = PH_TRAIL;
                        end
                    end
                    PH_TRAIL: begin
                        if (q_data.cls.space) begin
                            pending = 1'b0;
                        end else if (q_data.cls.cr) begin
                            ph      = PH_CR;
                            pending = 1'b0;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_CR: begin
                        if (q_data.cls.lf) begin
                            ph      = PH_DONE;
                            pending = 1'b0;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end
        end

        // result of the message on its final byte
        m_item_next.msg_type        = (!fail && ph == PH_DONE) ? cmd : MSG_ERROR;
        m_item_next.first_arg_len   = c1n;
        m_item_next.first_arg_text  = c1t;
        m_item_next.second_arg_len  = c2n;
        m_item_next.second_arg_text = c2t;

        // final byte returns the parser to its start
        if (q_data.last) begin
            phase_next    = PH_LEAD;
            prog_next     = 3'd0;
            alive_next    = '1;
            cmd_next      = MSG_ERROR;
            failed_next   = 1'b0;
            arg1_cnt_next = 4'd0;
            arg1_txt_next = '0;
            arg2_cnt_next = 4'd0;
            arg2_txt_next = '0;
        end else begin
            phase_next    = ph;
            prog_next     = prog;
            alive_next    = alive;
            cmd_next      = cmd;
            failed_next   = fail;
            arg1_cnt_next = c1n;
            arg1_txt_next = c1t;
            arg2_cnt_next = c2n;
            arg2_txt_next = c2t;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LEAD;
            prog_reg     <= 3'd0;
            alive_reg    <= '1;
            cmd_reg      <= MSG_ERROR;
            failed_reg   <= 1'b0;
            arg1_cnt_reg <= 4'd0;
            arg1_txt_reg <= '0;
            arg2_cnt_reg <= 4'd0;
            arg2_txt_reg <= '0;
        end else if (pop) begin
            phase_reg    <= phase_next;
            prog_reg     <= prog_next;
            alive_reg    <= alive_next;
            cmd_reg      <= cmd_next;
            failed_reg   <= failed_next;
            arg1_cnt_reg <= arg1_cnt_next;
            arg1_txt_reg <= arg1_txt_next;
            arg2_cnt_reg <= arg2_cnt_next;
            arg2_txt_reg <= arg2_txt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && q_data.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_data.last) begin
            m_item_reg <= m_item_next;
        end
    end

    // a final byte always leaves a result behind
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_data.last |=> m_valid_reg)
        else $error("final byte taken without a result");

    // a final byte clears the parser for the next message
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_data.last |=> phase_reg == PH_LEAD && !failed_reg
                               && arg1_cnt_reg == 4'd0 && arg2_cnt_reg == 4'd0)
        else $error("parser not cleared after final byte");

    // argument counts stay within the capture limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        arg1_cnt_reg <= MAX_LEN && arg2_cnt_reg <= MAX_LEN)
        else $error("argument count beyond limit");

    // a waiting result is never dropped
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("pending result lost");

endmodule

@@ rtl/core/text_command_line_parser_unit.sv @@
`timescale 1ns / 1ps
// text_command_line_parser_unit: top level of the command line parser
// depends on tclp_pkg, tclp_front, tclp_queue, tclp_back
//
//   channel   ports                      payload                 direction
//   input     s_valid s_ready s_item     in_item_t (byte, last)  in
//   result    m_valid m_ready m_item     out_item_t              out
//
// one byte per cycle sustained unless a final byte waits on a stalled result; each byte
// is registered in the two-entry queue, parsed by the back end as it leaves, and a final
// byte loads the result register. each parse is one pass through a chain of parser phases.
// reset (aresetn low, synchronous) empties the queue and returns the parser to its start.
// a stalled result holds only final bytes; other bytes keep draining into the parser.

module text_command_line_parser_unit #(
    parameter int MAX_ARG_CHARS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tclp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tclp_pkg::out_item_t m_item
);
    import tclp_pkg::*;

    q_entry_t front_entry;
    q_entry_t q_data;
    logic     q_valid;
    logic     q_ready;

    // byte classification
    tclp_front u_front (
        .in_item (s_item),
        .entry   (front_entry)
    );

    // decoupling queue
    tclp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // parser and result register
    tclp_back #(
        .MAX_ARG_CHARS (MAX_ARG_CHARS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
